// File: hdl/hsvrgbw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvrgbw_pkg
// Shared types and constants for the HSV to RGBW color converter.
// ============================================================================
package hsvrgbw_pkg;

    // Hue encoding: 256 steps per 60-degree sector, six sectors per turn.
    localparam int unsigned HUE_W      = 11;
    localparam int unsigned FRAC_W     = 8;
    localparam logic [HUE_W-1:0] HUE_TURN = 11'd1536;

    // Register port geometry.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_WHITE_MODE = 1'b0;

    // Hue sectors, named by the primaries they run between.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

endpackage

// File: hdl/hsvrgbw_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// hsvrgbw_regs
// APB-style register file: holds the white mode control bit.
// ============================================================================
module hsvrgbw_regs
    import hsvrgbw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_white_mode
);

    logic                 r_white_mode;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_mode <= 1'b0;
        end else if (wr_en && (reg_idx == REG_WHITE_MODE)) begin
            r_white_mode <= pwdata[0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WHITE_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, r_white_mode};
            default:        prdata = '0;
        endcase
    end

    assign o_white_mode = r_white_mode;

endmodule

// File: hdl/hsv_to_rgbw_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// hsv_to_rgbw_converter
// Six-stage pipelined fixed-point HSV to RGB / RGBW color converter.
// ============================================================================
// Usage:
//   Input channel : i_valid / o_stall carry one beat of hue, saturation and
//                   brightness. Hue counts 256 steps per 60 degrees; any hue
//                   of 1536 or more is read as 0.
//   Output channel: o_valid / i_stall carry one beat of red, green, blue and
//                   white levels for every input beat, in order.
//   Register port : APB-style, one register (white_mode, address 0). With
//                   white_mode set, the common part p moves to white and is
//                   removed from red, green and blue; else white is 0.
//   Throughput    : one beat per cycle, limited by nothing but the output
//                   handshake; every stage holds one beat.
//   Reset         : synchronous, active low; empties the pipeline and clears
//                   white_mode.
//   Stall         : each stage advances when it is empty or the stage after it
//                   advances, so bubbles squeeze out and a stalled output holds
//                   while the stages behind it keep filling; o_stall rises only
//                   when all six stages hold a beat.
// ============================================================================
module hsv_to_rgbw_converter
    import hsvrgbw_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input beats
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [HUE_W-1:0]        i_hue_position,
    input  logic [CHANNEL_BITS-1:0] i_saturation,
    input  logic [CHANNEL_BITS-1:0] i_brightness,
    // output beats
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CHANNEL_BITS-1:0] o_red_level,
    output logic [CHANNEL_BITS-1:0] o_green_level,
    output logic [CHANNEL_BITS-1:0] o_blue_level,
    output logic [CHANNEL_BITS-1:0] o_white_level,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CB     = CHANNEL_BITS;
    localparam int PW     = 2 * CB;        // v * (M - s) and the scaled sums
    localparam int QW     = CB + FRAC_W;   // s * f and 256M - s * f
    localparam int QPW    = PW + FRAC_W;   // v * (256M - s * f)
    localparam int NSTAGE = 6;

    // M = full scale. The q and t divisor is 256M; its half is 128M.
    localparam logic [CB-1:0]  CHAN_MAX = {CB{1'b1}};
    localparam logic [CB-1:0]  HALF_M   = {1'b0, {(CB-1){1'b1}}};
    localparam logic [QW-1:0]  DEN_Q    = {CHAN_MAX, {FRAC_W{1'b0}}};
    localparam logic [QPW-1:0] HALF_DEN = QPW'({CHAN_MAX, {(FRAC_W-1){1'b0}}});
    localparam logic [CB:0]    M_ONCE   = {1'b0, CHAN_MAX};
    localparam logic [CB:0]    M_TWICE  = {CHAN_MAX, 1'b0};

    // Lanes of the three scaled terms.
    localparam int LANE_P = 0;
    localparam int LANE_Q = 1;
    localparam int LANE_T = 2;

    // ------------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------------
    logic cfg_white_mode;

    hsvrgbw_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_white_mode (cfg_white_mode)
    );

    // ------------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor
    // advances. Valid bits travel with the data.
    // ------------------------------------------------------------------------
    logic [NSTAGE:1]   r_v;
    logic [NSTAGE+1:1] adv;

    always_comb begin
        adv[NSTAGE+1] = !i_stall;
        for (int k = NSTAGE; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: fold out-of-range hue to 0, split sector and fraction, form
    // s * f and s * (256 - f).
    // ------------------------------------------------------------------------
    logic [HUE_W-1:0]  hue_fold;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W:0]   frac_inv;

    t_sector           r1_sector;
    logic [CB-1:0]     r1_v;
    logic [CB-1:0]     r1_ms;
    logic [QW-1:0]     r1_sf;
    logic [QW-1:0]     r1_sfi;

    assign hue_fold = (i_hue_position >= HUE_TURN) ? '0 : i_hue_position;
    assign frac     = hue_fold[FRAC_W-1:0];
    assign frac_inv = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, frac};

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_sector <= t_sector'(hue_fold[HUE_W-1:FRAC_W]);
            r1_v      <= i_brightness;
            r1_ms     <= CHAN_MAX - i_saturation;
            r1_sf     <= QW'(i_saturation) * QW'(frac);
            r1_sfi    <= QW'(i_saturation) * QW'(frac_inv);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: multiply by v. Zero saturation needs no special path: every
    // term then rounds back to exactly v.
    // ------------------------------------------------------------------------
    t_sector           r2_sector;
    logic [CB-1:0]     r2_v;
    logic [PW-1:0]     r2_pp;
    logic [QPW-1:0]    r2_pq;
    logic [QPW-1:0]    r2_pt;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_sector <= r1_sector;
            r2_v      <= r1_v;
            r2_pp     <= PW'(r1_v) * PW'(r1_ms);
            r2_pq     <= QPW'(r1_v) * QPW'(DEN_Q - r1_sf);
            r2_pt     <= QPW'(r1_v) * QPW'(DEN_Q - r1_sfi);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: add the rounding half, drop the 256 factor, then fold the
    // division by M = 2^CB - 1: z = a*2^CB + b = a*M + (a + b).
    // ------------------------------------------------------------------------
    logic [QPW-1:0]         sum_q;
    logic [QPW-1:0]         sum_t;
    logic [2:0][PW-1:0]     z;

    t_sector                r3_sector;
    logic [CB-1:0]          r3_v;
    logic [2:0][CB-1:0]     r3_a;
    logic [2:0][CB:0]       r3_c;

    assign sum_q     = r2_pq + HALF_DEN;
    assign sum_t     = r2_pt + HALF_DEN;
    assign z[LANE_P] = r2_pp + PW'(HALF_M);
    assign z[LANE_Q] = sum_q[QPW-1:FRAC_W];
    assign z[LANE_T] = sum_t[QPW-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_sector <= r2_sector;
            r3_v      <= r2_v;
            for (int l = 0; l < 3; l++) begin
                r3_a[l] <= z[l][PW-1:CB];
                r3_c[l] <= {1'b0, z[l][PW-1:CB]} + {1'b0, z[l][CB-1:0]};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: correct the quotient; a + b is below 2^(CB+1), so it holds M
    // at most twice.
    // ------------------------------------------------------------------------
    function automatic logic [CB-1:0] quot_fix(input logic [CB-1:0] a, input logic [CB:0] c);
        logic [1:0] inc;
        inc = (c >= M_TWICE) ? 2'd2 : ((c >= M_ONCE) ? 2'd1 : 2'd0);
        return a + CB'(inc);
    endfunction

    t_sector                r4_sector;
    logic [CB-1:0]          r4_v;
    logic [2:0][CB-1:0]     r4_term;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_sector <= r3_sector;
            r4_v      <= r3_v;
            for (int l = 0; l < 3; l++) begin
                r4_term[l] <= quot_fix(r3_a[l], r3_c[l]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: place terms by sector, find the white share.
    // ------------------------------------------------------------------------
    logic [CB-1:0] n5_r;
    logic [CB-1:0] n5_g;
    logic [CB-1:0] n5_b;
    logic [CB-1:0] n5_lo;
    logic [CB-1:0] tp;
    logic [CB-1:0] tq;
    logic [CB-1:0] tt;

    logic [CB-1:0] r5_r;
    logic [CB-1:0] r5_g;
    logic [CB-1:0] r5_b;
    logic [CB-1:0] r5_lo;

    assign tp = r4_term[LANE_P];
    assign tq = r4_term[LANE_Q];
    assign tt = r4_term[LANE_T];

    always_comb begin
        case (r4_sector)
            SEC_RED_YELLOW:   begin n5_r = r4_v; n5_g = tt;   n5_b = tp;   end
            SEC_YELLOW_GREEN: begin n5_r = tq;   n5_g = r4_v; n5_b = tp;   end
            SEC_GREEN_CYAN:   begin n5_r = tp;   n5_g = r4_v; n5_b = tt;   end
            SEC_CYAN_BLUE:    begin n5_r = tp;   n5_g = tq;   n5_b = r4_v; end
            SEC_BLUE_MAGENTA: begin n5_r = tt;   n5_g = tp;   n5_b = r4_v; end
            default:          begin n5_r = r4_v; n5_g = tp;   n5_b = tq;   end
        endcase

        n5_lo = r4_v;
        if (tp < n5_lo) n5_lo = tp;
        if (tq < n5_lo) n5_lo = tq;
        if (tt < n5_lo) n5_lo = tt;
        if (!cfg_white_mode) n5_lo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_r  <= n5_r;
            r5_g  <= n5_g;
            r5_b  <= n5_b;
            r5_lo <= n5_lo;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: output register; remove the white share from the colors.
    // ------------------------------------------------------------------------
    logic [CB-1:0] r6_r;
    logic [CB-1:0] r6_g;
    logic [CB-1:0] r6_b;
    logic [CB-1:0] r6_w;

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_r <= r5_r - r5_lo;
            r6_g <= r5_g - r5_lo;
            r6_b <= r5_b - r5_lo;
            r6_w <= r5_lo;
        end
    end

    assign o_valid       = r_v[NSTAGE];
    assign o_red_level   = r6_r;
    assign o_green_level = r6_g;
    assign o_blue_level  = r6_b;
    assign o_white_level = r6_w;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_fills_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[1])
        else $error("accepted beat did not enter stage 1");

    a_no_stall_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NSTAGE] |-> !o_stall)
        else $error("input stalled while output stage is empty");

    a_white_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !cfg_white_mode) |-> (o_white_level == '0))
        else $error("white level nonzero with white mode off");

    a_white_on_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg_white_mode) |->
            ((o_red_level == '0) || (o_green_level == '0) || (o_blue_level == '0)))
        else $error("white split left no color channel at zero");

endmodule

// File: test/hsv_to_rgbw_converter_test.sv
`timescale 1ns / 1ps
// ============================================================================
// hsv_to_rgbw_converter_test
// Self-checking bench for the HSV to RGB / RGBW color converter. A driver
// feeds hue, saturation and brightness beats from a queue, and a monitor
// predicts each color and checks the output beats in order. Both sides idle
// and stall at random, and the white_mode register is changed between phases.
// ============================================================================
module hsv_to_rgbw_converter_test;
    import hsvrgbw_pkg::*;

    localparam int CB       = 8;
    localparam int CHAN_MAX = (1 << CB) - 1;
    localparam int FRAC_N   = 1 << FRAC_W;
    localparam int PHASE_N  = 300;
    localparam int LIMIT_NS = 2_000_000;

    // Index past the end of the register list; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_WHITE_MODE + 1'b1;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CB-1:0]    sat;
        logic [CB-1:0]    bri;
    } t_hsv;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
        logic [CB-1:0] white;
    } t_rgbw;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [HUE_W-1:0]      i_hue_position = '0;
    logic [CB-1:0]         i_saturation   = '0;
    logic [CB-1:0]         i_brightness   = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [CB-1:0]         o_red_level;
    logic [CB-1:0]         o_green_level;
    logic [CB-1:0]         o_blue_level;
    logic [CB-1:0]         o_white_level;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_hsv  colors_to_send[$];   // beats waiting for the driver
    t_rgbw colors_due[$];       // predicted colors, oldest first
    logic  white_mode_now = 1'b0;
    logic  hsv_beat_done  = 1'b0;
    logic  steady         = 1'b0;   // suppress idling and stalls when set
    int    mismatch_count = 0;

    hsv_to_rgbw_converter #(.CHANNEL_BITS(CB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_hue_position(i_hue_position), .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_red_level(o_red_level), .o_green_level(o_green_level),
        .o_blue_level(o_blue_level), .o_white_level(o_white_level),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Compute the color one HSV beat should produce under a given white mode.
    function automatic t_rgbw convert_hsv(t_hsv c, logic wm);
        logic [HUE_W-1:0] h;
        t_sector          sec;
        int unsigned      f, s, v, p, q, t, r, g, b, lo, den;
        t_rgbw            res;
        h   = (c.hue >= HUE_TURN) ? '0 : c.hue;   // out-of-range hue wraps to red
        sec = t_sector'(h[HUE_W-1:FRAC_W]);
        f   = 32'(h[FRAC_W-1:0]);
        s   = 32'(c.sat);
        v   = 32'(c.bri);
        den = CHAN_MAX * FRAC_N;
        if (s == 0) begin
            // gray: every component equals brightness
            p = v; q = v; t = v;
            r = v; g = v; b = v;
        end else begin
            p = (v * (CHAN_MAX - s) + CHAN_MAX / 2) / CHAN_MAX;
            q = (v * (den - s * f) + den / 2) / den;
            t = (v * (den - s * (FRAC_N - f)) + den / 2) / den;
            case (sec)
                SEC_RED_YELLOW: begin
                    r = v; g = t; b = p;
                end
                SEC_YELLOW_GREEN: begin
                    r = q; g = v; b = p;
                end
                SEC_GREEN_CYAN: begin
                    r = p; g = v; b = t;
                end
                SEC_CYAN_BLUE: begin
                    r = p; g = q; b = v;
                end
                SEC_BLUE_MAGENTA: begin
                    r = t; g = p; b = v;
                end
                default: begin
                    r = v; g = p; b = q;
                end
            endcase
        end
        if (wm) begin
            // move the common floor into the white channel
            lo = v;
            if (p < lo) lo = p;
            if (q < lo) lo = q;
            if (t < lo) lo = t;
            r = r - lo; g = g - lo; b = b - lo;
        end else begin
            lo = 0;
        end
        res.red   = r[CB-1:0];
        res.green = g[CB-1:0];
        res.blue  = b[CB-1:0];
        res.white = lo[CB-1:0];
        return res;
    endfunction

    task automatic check_level(input string name, input logic [CB-1:0] want,
                               input logic [CB-1:0] got);
        if (got !== want) begin
            $display("%0t: %s level mismatch, expected %0d, got %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: hold a beat until it is taken, then advance or idle at random.
    always @(negedge i_clk) begin : driver
        t_hsv nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || hsv_beat_done) begin
            if (colors_to_send.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
                nxt = colors_to_send.pop_front();
                i_valid        <= 1'b1;
                i_hue_position <= nxt.hue;
                i_saturation   <= nxt.sat;
                i_brightness   <= nxt.bri;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure: stall about a third of the time unless steady.
    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 31);
    end

    // Monitor: check output beats against predictions, then predict the
    // color for any input beat taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_rgbw want;
        t_hsv  taken;
        hsv_beat_done = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (colors_due.size() == 0) begin
                    $display("%0t: output beat with nothing expected, got r=%0d g=%0d b=%0d w=%0d",
                             $time, o_red_level, o_green_level, o_blue_level,
                             o_white_level);
                    mismatch_count++;
                end else begin
                    want = colors_due.pop_front();
                    check_level("red", want.red, o_red_level);
                    check_level("green", want.green, o_green_level);
                    check_level("blue", want.blue, o_blue_level);
                    check_level("white", want.white, o_white_level);
                end
            end
            if (i_valid && !o_stall) begin
                hsv_beat_done = 1'b1;
                taken.hue = i_hue_position;
                taken.sat = i_saturation;
                taken.bri = i_brightness;
                colors_due.push_back(convert_hsv(taken, white_mode_now));
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_WHITE_MODE) white_mode_now = value[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_white_mode_readback();
        logic [APB_DATA_W-1:0] want;
        want = APB_DATA_W'(white_mode_now);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_WHITE_MODE, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: white_mode readback mismatch, expected %0h, got %0h",
                     $time, want, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every queued beat is sent and every color has come back,
    // then let the pipeline settle.
    task automatic drain();
        while (colors_to_send.size() != 0 || i_valid || colors_due.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic queue_hsv(input int hue, input int sat, input int bri);
        t_hsv c;
        c.hue = hue[HUE_W-1:0];
        c.sat = sat[CB-1:0];
        c.bri = bri[CB-1:0];
        colors_to_send.push_back(c);
    endtask

    // Corners: black, full red, the sector edges but 1024, wrapped hue, gray.
    task automatic queue_corners();
        queue_hsv(0, 0, 0);
        queue_hsv(0, 255, 255);
        queue_hsv(255, 255, 255);
        queue_hsv(256, 255, 255);
        queue_hsv(512, 128, 200);
        queue_hsv(768, 200, 100);
        queue_hsv(1280, 77, 250);
        queue_hsv(1535, 255, 255);
        queue_hsv(1536, 255, 255);
        queue_hsv(2047, 255, 200);
        queue_hsv(700, 0, 180);
        queue_hsv(100, 1, 255);
    endtask

    task automatic queue_random(input int n);
        int hue, sat, bri;
        repeat (n) begin
            case ($urandom_range(9))
                0:       hue = $urandom_range(2047, 1536);
                1:       hue = $urandom_range(5) * 256 + ($urandom_range(1) ? 255 : 0);
                default: hue = $urandom_range(1535);
            endcase
            case ($urandom_range(7))
                0:       sat = 0;
                1:       sat = 255;
                default: sat = $urandom_range(255);
            endcase
            case ($urandom_range(7))
                0:       bri = 0;
                1:       bri = 255;
                default: bri = $urandom_range(255);
            endcase
            queue_hsv(hue, sat, bri);
        end
    endtask

    initial begin : stimulus
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of white_mode, then corners in plain RGB.
        check_white_mode_readback();
        queue_corners();
        drain();

        // Set white mode with junk in the upper bits; a write past the list
        // must leave it alone.
        reg_write(REG_WHITE_MODE, 32'hFFFF_FFFF);
        reg_write(REG_UNMAPPED, 32'h0000_0000);
        check_white_mode_readback();
        queue_corners();
        queue_random(PHASE_N / 2);
        // Hold the sender until the pipeline is empty, then resume.
        drain();
        queue_random(PHASE_N / 2);
        drain();

        // Back to plain RGB; run the first half without idling or stalls.
        reg_write(REG_WHITE_MODE, 32'hFFFF_FFFE);
        check_white_mode_readback();
        steady = 1'b1;
        queue_random(PHASE_N / 2);
        drain();
        steady = 1'b0;
        queue_random(PHASE_N / 2);
        drain();

        reg_write(REG_WHITE_MODE, 32'h0000_0001);
        check_white_mode_readback();
        queue_random(PHASE_N);
        drain();

        if (mismatch_count == 0) begin
            $display("PASS hsv_to_rgbw_converter");
        end else begin
            $display("FAIL hsv_to_rgbw_converter");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("FAIL hsv_to_rgbw_converter");
        $finish;
    end

endmodule
